// ----- sv/hlpae_pkg.sv -----
package hlpae_pkg;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [15:0] nir_sample;
        logic        frame_end;
    } t_pix_in;

    typedef struct packed {
        logic [19:0] wl_exposure;
        logic [19:0] nir_exposure;
        logic [11:0] wl_cutoff;
        logic [11:0] nir_cutoff;
        logic [20:0] signal_pixels;
    } t_result;

    // Classified pixel as it travels from the front end to the histogram engine.
    typedef struct packed {
        logic [11:0] luma;
        logic [11:0] nir;
        logic        sig;
        logic        last;
    } t_qitem;

    typedef struct packed {
        logic [11:0] target_cutoff;
        logic [11:0] mask_threshold;
        logic        dual_mode;
        logic [19:0] min_exposure;
        logic [19:0] wl_max_exposure;
        logic [19:0] nir_max_exposure;
    } t_cfg;

    typedef struct packed {
        logic        we;
        logic [2:0]  idx;
        logic [19:0] data;
    } t_cfg_wr;

    typedef enum logic [2:0] {
        CFG_TARGET_CUTOFF  = 3'd0,
        CFG_MASK_THRESHOLD = 3'd1,
        CFG_DUAL_MODE      = 3'd2,
        CFG_WL_EXP_START   = 3'd3,
        CFG_NIR_EXP_START  = 3'd4,
        CFG_MIN_EXPOSURE   = 3'd5,
        CFG_WL_MAX_EXP     = 3'd6,
        CFG_NIR_MAX_EXP    = 3'd7
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_CLR,
        ST_RUN,
        ST_SCAN,
        ST_DRAIN,
        ST_DLOAD,
        ST_DIV,
        ST_MSEL,
        ST_MUL,
        ST_UPD,
        ST_OUT
    } t_bstate;

    localparam int unsigned Q_DEPTH = 4;

    localparam logic [19:0] LUMA_CR = 20'd860;
    localparam logic [19:0] LUMA_CG = 20'd2949;
    localparam logic [19:0] LUMA_CB = 20'd287;
    localparam logic [15:0] NIR_SAT = 16'd4095;

    localparam logic [16:0] MUL_MIN_Q16 = 17'd58982;
    localparam logic [16:0] MUL_MAX_Q16 = 17'd72090;
    localparam logic [17:0] MUL_TWO_Q16 = 18'd131072;

    localparam logic [11:0] RST_TARGET  = 12'd2048;
    localparam logic [11:0] RST_MASK    = 12'd32;
    localparam logic [19:0] RST_WL_EXP  = 20'd80000;
    localparam logic [19:0] RST_NIR_EXP = 20'd300000;
    localparam logic [19:0] RST_MIN     = 20'd100;
    localparam logic [19:0] RST_WL_MAX  = 20'd120000;
    localparam logic [19:0] RST_NIR_MAX = 20'd550000;

endpackage

// ----- sv/hlpae_front.sv -----
module hlpae_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  hlpae_pkg::t_pix_in  i_pix,
    input  logic [11:0]         i_mask,
    output logic                o_push,
    input  logic                i_full,
    output hlpae_pkg::t_qitem   o_item
);
    import hlpae_pkg::*;

    logic        r_v;
    t_qitem      r_item;
    logic [19:0] w_sum;
    logic [11:0] w_luma;
    logic [11:0] w_nir;
    logic        w_accept;

    always_comb begin
        w_sum  = LUMA_CR * 20'(i_pix.red) + LUMA_CG * 20'(i_pix.green)
               + LUMA_CB * 20'(i_pix.blue);
        w_luma = w_sum[19:8];
        w_nir  = (i_pix.nir_sample > NIR_SAT) ? NIR_SAT[11:0] : i_pix.nir_sample[11:0];
    end

    assign o_stall  = r_v && i_full;
    assign o_push   = r_v && !i_full;
    assign w_accept = i_valid && !o_stall;
    assign o_item   = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_accept) begin
            r_v <= 1'b1;
        end else if (o_push) begin
            r_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.luma <= w_luma;
            r_item.nir  <= w_nir;
            r_item.sig  <= (w_luma > i_mask);
            r_item.last <= i_pix.frame_end;
        end
    end

endmodule

// ----- sv/hlpae_fifo.sv -----
module hlpae_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  hlpae_pkg::t_qitem  i_item,
    output logic               o_full,
    input  logic               i_pop,
    output hlpae_pkg::t_qitem  o_item,
    output logic               o_empty
);
    import hlpae_pkg::*;

    localparam int unsigned PW = $clog2(Q_DEPTH);
    localparam int unsigned NW = $clog2(Q_DEPTH + 1);

    t_qitem        r_mem [Q_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [NW-1:0] r_n;

    assign o_full  = (r_n == NW'(Q_DEPTH));
    assign o_empty = (r_n == '0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_n  <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_n <= r_n + 1'b1;
            end else if (!i_push && i_pop) begin
                r_n <= r_n - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

// ----- sv/hlpae_back.sv -----
module hlpae_back #(
    parameter int unsigned MAX_PIXELS = 1048576,
    parameter int unsigned HIST_BINS  = 4096
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_empty,
    output logic                o_pop,
    input  hlpae_pkg::t_qitem   i_item,
    input  hlpae_pkg::t_cfg     i_cfg,
    input  hlpae_pkg::t_cfg_wr  i_cfg_wr,
    output logic                o_valid,
    input  logic                i_stall,
    output hlpae_pkg::t_result  o_res
);
    import hlpae_pkg::*;

    localparam int unsigned BW  = $clog2(HIST_BINS);
    localparam int unsigned CW  = $clog2(MAX_PIXELS + 1);
    localparam int unsigned SW  = CW + 1;
    localparam int unsigned TW  = SW + 5;
    localparam int unsigned DW  = BW + 16;
    localparam int unsigned DCW = $clog2(DW + 1);
    localparam logic [BW-1:0] LAST_BIN = BW'(HIST_BINS - 1);
    localparam logic [CW-1:0] MAXP     = CW'(MAX_PIXELS);

    function automatic logic [BW-1:0] sat_bin(input logic [11:0] v);
        logic [16:0] w;
        w = {5'b0, v};
        if (w > 17'(HIST_BINS - 1)) begin
            return LAST_BIN;
        end
        return w[BW-1:0];
    endfunction

    t_bstate r_state;
    t_bstate n_state;

    // Histogram memories
    logic [CW-1:0] r_lmem [HIST_BINS];
    logic [CW-1:0] r_nmem [HIST_BINS];
    logic [CW-1:0] r_lrd;
    logic [CW-1:0] r_nrd;
    logic [BW-1:0] w_lra;
    logic [BW-1:0] w_nra;
    logic [BW-1:0] w_lwa;
    logic [BW-1:0] w_nwa;
    logic [CW-1:0] w_lwd;
    logic [CW-1:0] w_nwd;
    logic          w_we;

    // Update pipeline
    logic          r_p_v;
    logic [BW-1:0] r_p_lbin;
    logic [BW-1:0] r_p_nbin;
    logic          r_p_sig;
    logic          r_p_last;
    logic          r_w_v;
    logic [BW-1:0] r_w_laddr;
    logic [BW-1:0] r_w_naddr;
    logic [CW-1:0] r_w_ldata;
    logic [CW-1:0] r_w_ndata;
    logic [CW-1:0] w_lold;
    logic [CW-1:0] w_nold;
    logic          r_lastpend;
    logic [CW-1:0] r_cnt;

    // Sweep and percentile search
    logic [BW-1:0] r_addr;
    logic          r_dv;
    logic [BW-1:0] r_didx;
    logic [SW-1:0] r_lsum;
    logic [SW-1:0] r_nsum;
    logic          r_lfound;
    logic          r_nfound;
    logic [BW-1:0] r_lcut;
    logic [BW-1:0] r_ncut;
    logic [SW-1:0] w_lsum;
    logic [SW-1:0] w_nsum;
    logic [TW-1:0] w_lim;
    logic          w_lhit;
    logic          w_nhit;

    // Multiplier calculation
    logic           r_ch;
    logic [11:0]    r_rem;
    logic [DW-1:0]  r_dq;
    logic [DCW-1:0] r_dcnt;
    logic [11:0]    w_tgt;
    logic [12:0]    w_trial;
    logic           w_qbit;
    logic [16:0]    r_m;
    logic [17:0]    w_mdiff;
    logic [36:0]    r_prod;
    logic [20:0]    w_e;
    logic [19:0]    w_max;
    logic [19:0]    r_wl_run;
    logic [19:0]    r_nir_run;

    logic           r_o_valid;
    t_result        r_res;
    logic [31:0]    w_lcut32;
    logic [31:0]    w_ncut32;
    logic [31:0]    w_cnt32;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLR:   if (r_addr == LAST_BIN) n_state = ST_RUN;
            ST_RUN:   if (r_p_v && r_p_last) n_state = ST_SCAN;
            ST_SCAN:  if (r_addr == LAST_BIN) n_state = ST_DRAIN;
            ST_DRAIN: n_state = ST_DLOAD;
            ST_DLOAD: n_state = ST_DIV;
            ST_DIV:   if (r_dcnt == DCW'(DW - 1)) n_state = ST_MSEL;
            ST_MSEL:  n_state = ST_MUL;
            ST_MUL:   n_state = ST_UPD;
            ST_UPD:   n_state = (!r_ch && i_cfg.dual_mode) ? ST_DLOAD : ST_OUT;
            ST_OUT:   if (!r_o_valid || !i_stall) n_state = ST_RUN;
            default:  n_state = ST_CLR;
        endcase
    end

    // Memory port control
    always_comb begin
        o_pop = 1'b0;
        w_we  = 1'b0;
        w_lra = r_addr;
        w_nra = r_addr;
        w_lwa = r_addr;
        w_nwa = r_addr;
        w_lwd = '0;
        w_nwd = '0;
        w_lold = (r_w_v && r_w_laddr == r_p_lbin) ? r_w_ldata : r_lrd;
        w_nold = (r_w_v && r_w_naddr == r_p_nbin) ? r_w_ndata : r_nrd;
        unique case (r_state)
            ST_CLR, ST_SCAN: begin
                w_we = 1'b1;
            end
            ST_RUN: begin
                o_pop = !i_empty && !r_lastpend;
                w_lra = sat_bin(i_item.luma);
                w_nra = sat_bin(i_item.nir);
                w_we  = r_p_v && r_p_sig;
                w_lwa = r_p_lbin;
                w_nwa = r_p_nbin;
                w_lwd = (w_lold < MAXP) ? w_lold + 1'b1 : w_lold;
                w_nwd = (w_nold < MAXP) ? w_nold + 1'b1 : w_nold;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_lmem[w_lwa] <= w_lwd;
        end
        r_lrd <= r_lmem[w_lra];
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_nmem[w_nwa] <= w_nwd;
        end
        r_nrd <= r_nmem[w_nra];
    end

    // Percentile test: a bin is the cutoff once 20 * sum exceeds 19 * count.
    always_comb begin
        w_lsum = r_lsum + SW'(r_lrd);
        w_nsum = r_nsum + SW'(r_nrd);
        w_lim  = TW'(r_cnt) * TW'(19);
        w_lhit = (TW'(w_lsum) * TW'(20)) > w_lim;
        w_nhit = (TW'(w_nsum) * TW'(20)) > w_lim;
    end

    // Divider step, multiplier selection and exposure clamp
    always_comb begin
        w_tgt   = (i_cfg.target_cutoff == '0) ? 12'd1 : i_cfg.target_cutoff;
        w_trial = {r_rem, r_dq[DW-1]};
        w_qbit  = (w_trial >= {1'b0, w_tgt});
        w_mdiff = MUL_TWO_Q16 - 18'(r_dq);
        w_max   = r_ch ? i_cfg.nir_max_exposure : i_cfg.wl_max_exposure;
        w_e     = r_prod[36:16];
        if (w_e < {1'b0, i_cfg.min_exposure}) begin
            w_e = {1'b0, i_cfg.min_exposure};
        end
        if (w_e > {1'b0, w_max}) begin
            w_e = {1'b0, w_max};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLR;
            r_addr     <= '0;
            r_p_v      <= 1'b0;
            r_w_v      <= 1'b0;
            r_lastpend <= 1'b0;
            r_cnt      <= '0;
            r_dv       <= 1'b0;
            r_lsum     <= '0;
            r_nsum     <= '0;
            r_lfound   <= 1'b0;
            r_nfound   <= 1'b0;
            r_lcut     <= '0;
            r_ncut     <= '0;
            r_ch       <= 1'b0;
            r_dcnt     <= '0;
            r_wl_run   <= RST_WL_EXP;
            r_nir_run  <= RST_NIR_EXP;
            r_o_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_p_v   <= o_pop;
            r_w_v   <= (r_state == ST_RUN) && r_p_v && r_p_sig;
            r_dv    <= (r_state == ST_SCAN);
            if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end
            if (i_cfg_wr.we && t_cfg_idx'(i_cfg_wr.idx) == CFG_WL_EXP_START) begin
                r_wl_run <= i_cfg_wr.data;
            end
            if (i_cfg_wr.we && t_cfg_idx'(i_cfg_wr.idx) == CFG_NIR_EXP_START) begin
                r_nir_run <= i_cfg_wr.data;
            end
            if (o_pop) begin
                if (i_item.last) begin
                    r_lastpend <= 1'b1;
                end
                if (i_item.sig && r_cnt < MAXP) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            if (r_dv) begin
                if (!r_lfound) begin
                    r_lsum <= w_lsum;
                    if (w_lhit) begin
                        r_lfound <= 1'b1;
                        r_lcut   <= r_didx;
                    end
                end
                if (!r_nfound) begin
                    r_nsum <= w_nsum;
                    if (w_nhit) begin
                        r_nfound <= 1'b1;
                        r_ncut   <= r_didx;
                    end
                end
            end
            unique case (r_state)
                ST_CLR, ST_SCAN: begin
                    r_addr <= r_addr + 1'b1;
                end
                ST_RUN: begin
                    r_addr <= '0;
                    r_ch   <= 1'b0;
                end
                ST_DLOAD: begin
                    r_dcnt <= '0;
                end
                ST_DIV: begin
                    r_dcnt <= r_dcnt + 1'b1;
                end
                ST_UPD: begin
                    if (r_ch) begin
                        r_nir_run <= w_e[19:0];
                    end else begin
                        r_wl_run <= w_e[19:0];
                    end
                    r_ch <= 1'b1;
                end
                ST_OUT: begin
                    if (!r_o_valid || !i_stall) begin
                        r_o_valid  <= 1'b1;
                        r_lastpend <= 1'b0;
                        r_cnt      <= '0;
                        r_lsum     <= '0;
                        r_nsum     <= '0;
                        r_lfound   <= 1'b0;
                        r_nfound   <= 1'b0;
                        r_lcut     <= '0;
                        r_ncut     <= '0;
                    end
                end
                default: begin
                    r_dcnt <= r_dcnt;
                end
            endcase
        end
    end

    always_comb begin
        w_lcut32 = 32'(r_lcut);
        w_ncut32 = i_cfg.dual_mode ? 32'(r_ncut) : 32'd0;
        w_cnt32  = 32'(r_cnt);
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_didx <= r_addr;
        if (o_pop) begin
            r_p_lbin <= w_lra;
            r_p_nbin <= w_nra;
            r_p_sig  <= i_item.sig;
            r_p_last <= i_item.last;
        end
        r_w_laddr <= r_p_lbin;
        r_w_naddr <= r_p_nbin;
        r_w_ldata <= w_lwd;
        r_w_ndata <= w_nwd;
        unique case (r_state)
            ST_DLOAD: begin
                r_rem <= '0;
                r_dq  <= {(r_ch ? r_ncut : r_lcut), 16'd0};
            end
            ST_DIV: begin
                r_rem <= w_qbit ? 12'(w_trial - {1'b0, w_tgt}) : w_trial[11:0];
                r_dq  <= {r_dq[DW-2:0], w_qbit};
            end
            ST_MSEL: begin
                if (r_dq >= DW'(MUL_MAX_Q16)) begin
                    r_m <= MUL_MIN_Q16;
                end else if (r_dq <= DW'(MUL_MIN_Q16)) begin
                    r_m <= MUL_MAX_Q16;
                end else begin
                    r_m <= w_mdiff[16:0];
                end
            end
            ST_MUL: begin
                r_prod <= 37'(r_ch ? r_nir_run : r_wl_run) * 37'(r_m);
            end
            ST_OUT: begin
                if (!r_o_valid || !i_stall) begin
                    r_res.wl_exposure   <= r_wl_run;
                    r_res.nir_exposure  <= r_nir_run;
                    r_res.wl_cutoff     <= w_lcut32[11:0];
                    r_res.nir_cutoff    <= w_ncut32[11:0];
                    r_res.signal_pixels <= w_cnt32[20:0];
                end
            end
            default: begin
                r_rem <= r_rem;
            end
        endcase
    end

    assign o_valid = r_o_valid;
    assign o_res   = r_res;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= MAXP)
        else $error("pixel count above saturation limit");

    a_pop_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == ST_RUN) && !r_lastpend)
        else $error("queue popped outside pixel phase");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> $past(r_state == ST_OUT))
        else $error("result loaded outside output state");

    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_dcnt < DCW'(DW)))
        else $error("divider ran past its step count");
`endif

endmodule

// ----- sv/histogram_percentile_auto_exposure_top.sv -----
// Pixels are taken at one per cycle within a frame while the queue is not full; a pixel
// reaches the histograms through the front-end register, the queue and the update pipeline.
// A frame's result is valid once its last pixel has been accepted and the block has made one
// pass over the histogram memories, which also clears them, then a serial 28-step division
// and the multiplier per camera (white light only in single mode). No pixel is binned then.
// Synchronous active-low reset; afterwards the histograms are swept clear.
module histogram_percentile_auto_exposure_top #(
    parameter int unsigned MAX_PIXELS = 1048576,
    parameter int unsigned HIST_BINS  = 4096
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  hlpae_pkg::t_pix_in  i_pix,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output hlpae_pkg::t_result  o_res,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [19:0]         i_cfg_data
);
    import hlpae_pkg::*;

    t_cfg    r_cfg;
    t_cfg_wr w_cfg_wr;
    t_qitem  w_fitem;
    t_qitem  w_qitem;
    logic    w_push;
    logic    w_full;
    logic    w_pop;
    logic    w_empty;

    assign w_cfg_wr.we   = i_cfg_we;
    assign w_cfg_wr.idx  = i_cfg_idx;
    assign w_cfg_wr.data = i_cfg_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_cutoff    <= RST_TARGET;
            r_cfg.mask_threshold   <= RST_MASK;
            r_cfg.dual_mode        <= 1'b1;
            r_cfg.min_exposure     <= RST_MIN;
            r_cfg.wl_max_exposure  <= RST_WL_MAX;
            r_cfg.nir_max_exposure <= RST_NIR_MAX;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_TARGET_CUTOFF:  r_cfg.target_cutoff    <= i_cfg_data[11:0];
                CFG_MASK_THRESHOLD: r_cfg.mask_threshold   <= i_cfg_data[11:0];
                CFG_DUAL_MODE:      r_cfg.dual_mode        <= i_cfg_data[0];
                CFG_MIN_EXPOSURE:   r_cfg.min_exposure     <= i_cfg_data;
                CFG_WL_MAX_EXP:     r_cfg.wl_max_exposure  <= i_cfg_data;
                CFG_NIR_MAX_EXP:    r_cfg.nir_max_exposure <= i_cfg_data;
                default:            r_cfg                  <= r_cfg;
            endcase
        end
    end

    hlpae_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_pix   (i_pix),
        .i_mask  (r_cfg.mask_threshold),
        .o_push  (w_push),
        .i_full  (w_full),
        .o_item  (w_fitem)
    );

    hlpae_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_fitem),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_item  (w_qitem),
        .o_empty (w_empty)
    );

    hlpae_back #(
        .MAX_PIXELS (MAX_PIXELS),
        .HIST_BINS  (HIST_BINS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (w_empty),
        .o_pop    (w_pop),
        .i_item   (w_qitem),
        .i_cfg    (r_cfg),
        .i_cfg_wr (w_cfg_wr),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_res    (o_res)
    );

endmodule

// ----- tb/tb_histogram_percentile_auto_exposure_top.sv -----
module tb_histogram_percentile_auto_exposure_top;
    import hlpae_pkg::*;

    localparam int unsigned NBINS = 4096;
    localparam int unsigned PIX_CAP = 1048576;
    localparam int unsigned SETTLE = NBINS + 200;
    localparam longint CYCLE_LIMIT = 64'd40000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_pix_in     i_pix = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_result     o_res;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [19:0] i_cfg_data = '0;

    histogram_percentile_auto_exposure_top u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_pix(i_pix),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_res(o_res),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Shadow copy of the block's registers and frame state.
    logic [11:0] m_target, m_mask;
    logic        m_dual;
    logic [19:0] m_min, m_wl_max, m_nir_max, m_wl_exp, m_nir_exp;
    int unsigned luma_hist [NBINS];
    int unsigned nir_hist [NBINS];
    int unsigned sig_count;

    t_result     expected_frames [$];
    int          mismatches = 0;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    longint      cycles = 0;

    function automatic int unsigned percentile_bin(input int unsigned cnt, input bit use_nir);
        longint unsigned acc;
        acc = 0;
        for (int i = 0; i < NBINS; i++) begin
            acc += use_nir ? nir_hist[i] : luma_hist[i];
            if (acc * 20 > longint'(cnt) * 19)
                return i;
        end
        return 0;
    endfunction

    function automatic logic [19:0] scale_exposure(input logic [19:0] running,
                                                   input int unsigned cut,
                                                   input logic [19:0] maxv);
        longint unsigned tgt, q, m, e;
        tgt = (m_target == 0) ? 1 : m_target;
        q = (longint'(cut) << 16) / tgt;
        m = (q >= 131072) ? 0 : 131072 - q;
        if (m > 72090) m = 72090;
        if (m < 58982) m = 58982;
        e = (longint'(running) * m) >> 16;
        if (e < m_min) e = m_min;
        if (e > maxv) e = maxv;
        return e[19:0];
    endfunction

    task automatic clear_frame_state();
        for (int i = 0; i < NBINS; i++) begin
            luma_hist[i] = 0;
            nir_hist[i] = 0;
        end
        sig_count = 0;
    endtask

    task automatic predict_pixel(input t_pix_in p);
        int unsigned luma, nir, wcut, ncut;
        t_result r;
        luma = (860 * p.red + 2949 * p.green + 287 * p.blue) >> 8;
        nir = (p.nir_sample > 4095) ? 4095 : p.nir_sample;
        if (luma > m_mask) begin
            if (luma > NBINS - 1) luma = NBINS - 1;
            if (luma_hist[luma] < PIX_CAP) luma_hist[luma]++;
            if (nir_hist[nir] < PIX_CAP) nir_hist[nir]++;
            if (sig_count < PIX_CAP) sig_count++;
        end
        if (p.frame_end) begin
            ncut = 0;
            wcut = percentile_bin(sig_count, 1'b0);
            m_wl_exp = scale_exposure(m_wl_exp, wcut, m_wl_max);
            if (m_dual) begin
                ncut = percentile_bin(sig_count, 1'b1);
                m_nir_exp = scale_exposure(m_nir_exp, ncut, m_nir_max);
            end
            r.wl_exposure = m_wl_exp;
            r.nir_exposure = m_nir_exp;
            r.wl_cutoff = wcut[11:0];
            r.nir_cutoff = ncut[11:0];
            r.signal_pixels = sig_count[20:0];
            expected_frames.push_back(r);
            clear_frame_state();
        end
    endtask

    // Valid stays high after a request so that the next one can follow at once;
    // an idle cycle or wait_idle drops it.
    task automatic send_pixel(input t_pix_in p);
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pix <= p;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_pixel(p);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [19:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_TARGET_CUTOFF:  m_target = val[11:0];
            CFG_MASK_THRESHOLD: m_mask = val[11:0];
            CFG_DUAL_MODE:      m_dual = val[0];
            CFG_WL_EXP_START:   m_wl_exp = val;
            CFG_NIR_EXP_START:  m_nir_exp = val;
            CFG_MIN_EXPOSURE:   m_min = val;
            CFG_WL_MAX_EXP:     m_wl_max = val;
            CFG_NIR_MAX_EXP:    m_nir_max = val;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // Registers change only once the block has gone quiet.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_frames.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    function automatic t_pix_in rand_pixel(input bit last);
        t_pix_in p;
        p.red = 8'($urandom_range(255, 0));
        p.green = 8'($urandom_range(255, 0));
        p.blue = 8'($urandom_range(255, 0));
        case ($urandom_range(3, 0))
            0: p.nir_sample = 16'($urandom_range(65535, 0));
            1: p.nir_sample = 16'($urandom_range(4100, 4090));
            default: p.nir_sample = 16'($urandom_range(4095, 0));
        endcase
        p.frame_end = last;
        return p;
    endfunction

    task automatic send_frame(input int npix);
        for (int i = 0; i < npix; i++)
            send_pixel(rand_pixel(i == npix - 1));
    endtask

    always @(posedge i_clk) begin
        if (o_out_valid && !i_out_stall) begin
            if (expected_frames.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result %p", o_res);
            end else begin
                t_result e;
                e = expected_frames.pop_front();
                if (e !== o_res) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected %p, got %p", e, o_res);
                end
            end
        end
    end

    always @(negedge i_clk)
        i_out_stall <= (stall_pct > 0) && ($urandom_range(99, 0) < stall_pct);

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic test_directed();
        t_pix_in p;
        // Empty frame: a single dark pixel gives no signal.
        p = '0;
        p.frame_end = 1'b1;
        send_pixel(p);
        // Extremes of every field, last pixel bright.
        p = '{8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 1'b0};
        send_pixel(p);
        p = '{8'hFF, 8'h00, 8'h00, 16'h0FFF, 1'b0};
        send_pixel(p);
        p = '{8'h00, 8'hFF, 8'h00, 16'h1000, 1'b0};
        send_pixel(p);
        p = '{8'h00, 8'h00, 8'hFF, 16'h0000, 1'b0};
        send_pixel(p);
        p = '{8'hAA, 8'h55, 8'hAA, 16'h5555, 1'b0};
        send_pixel(p);
        p = '{8'h55, 8'hAA, 8'h55, 16'hAAAA, 1'b1};
        send_pixel(p);
        wait_idle();
        // Target zero, crossed clamps, single mode.
        write_reg(CFG_TARGET_CUTOFF, 20'd0);
        write_reg(CFG_MIN_EXPOSURE, 20'd200000);
        write_reg(CFG_DUAL_MODE, 20'd0);
        send_frame(6);
        wait_idle();
        write_reg(CFG_TARGET_CUTOFF, 20'd4095);
        write_reg(CFG_MASK_THRESHOLD, 20'd4095);
        write_reg(CFG_DUAL_MODE, 20'd1);
        send_frame(4);
        wait_idle();
    endtask

    task automatic test_random_config();
        logic [19:0] hi;
        write_reg(CFG_TARGET_CUTOFF, 20'($urandom_range(4095, 1)));
        write_reg(CFG_MASK_THRESHOLD, 20'(($urandom_range(3, 0) == 0)
                                          ? $urandom_range(4095, 0)
                                          : $urandom_range(600, 0)));
        write_reg(CFG_DUAL_MODE, 20'($urandom_range(1, 0)));
        hi = $urandom_range(1, 0) ? 20'hFFFFF : 20'h00000;
        write_reg(CFG_WL_EXP_START, ($urandom_range(3, 0) == 0) ? hi
                                    : 20'($urandom_range(1048575, 0)));
        write_reg(CFG_NIR_EXP_START, 20'($urandom_range(1048575, 0)));
        write_reg(CFG_MIN_EXPOSURE, ($urandom_range(3, 0) == 0) ? hi
                                    : 20'($urandom_range(5000, 0)));
        write_reg(CFG_WL_MAX_EXP, ($urandom_range(3, 0) == 0) ? 20'hFFFFF
                                  : 20'($urandom_range(1048575, 0)));
        write_reg(CFG_NIR_MAX_EXP, 20'($urandom_range(1048575, 0)));
    endtask

    task automatic test_random_phase(input int idle, input int stall, input int npix);
        int sent;
        send_idle_pct = idle;
        stall_pct = stall;
        test_random_config();
        sent = 0;
        while (sent < npix) begin
            int n;
            n = $urandom_range(40, 1);
            send_frame(n);
            sent += n;
        end
        wait_idle();
    endtask

    initial begin
        m_target = RST_TARGET;
        m_mask = RST_MASK;
        m_dual = 1'b1;
        m_wl_exp = RST_WL_EXP;
        m_nir_exp = RST_NIR_EXP;
        m_min = RST_MIN;
        m_wl_max = RST_WL_MAX;
        m_nir_max = RST_NIR_MAX;
        clear_frame_state();
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_phase(0, 0, 460);
        test_random_phase(69, 0, 460);
        test_random_phase(0, 69, 460);
        test_random_phase(31, 31, 460);
        stall_pct = 0;
        wait_idle();
        if (mismatches == 0 && expected_frames.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
